>>> sv/gsp_pkg.sv
// Shared types, constants and the character-to-septet map of the septet packer.
// No dependencies; every other file imports this package.
package gsp_pkg;

   // septet that stands for any character outside the default alphabet
   localparam logic [6:0] UNKNOWN_SEPTET = 7'h3f;

   // register indexes of the configuration port
   localparam logic CSR_FILL_BITS = 1'b0;

   // one queued word: translated septet and end-of-message mark
   typedef struct packed {
      logic [6:0] septet;
      logic       last;
   } q_entry_type;

   // queue state as seen by the front and back ends
   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   // packer state reported to the top level
   typedef struct packed {
      logic flush_pending;
      logic at_start;
   } back_status_type;

   // reverse lookup into the default alphabet, first match wins
   function automatic logic [6:0] to_septet(input logic [7:0] ch);
      logic [6:0] sept;
      sept = UNKNOWN_SEPTET;
      // printable runs that sit at their own code point
      if ((ch >= 8'h20 && ch <= 8'h3e && ch != 8'h24) ||
          (ch >= 8'h41 && ch <= 8'h5a) ||
          (ch >= 8'h61 && ch <= 8'h7a)) begin
         sept = ch[6:0];
      end else begin
         case (ch)
            8'h40:   sept = 7'h00;
            8'ha3:   sept = 7'h01;
            8'h24:   sept = 7'h02;
            8'ha5:   sept = 7'h03;
            8'he8:   sept = 7'h04;
            8'he9:   sept = 7'h05;
            8'hf9:   sept = 7'h06;
            8'hec:   sept = 7'h07;
            8'hf2:   sept = 7'h08;
            8'hc7:   sept = 7'h09;
            8'h0a:   sept = 7'h0a;
            8'hd8:   sept = 7'h0b;
            8'hf8:   sept = 7'h0c;
            8'h0d:   sept = 7'h0d;
            8'hc5:   sept = 7'h0e;
            8'he5:   sept = 7'h0f;
            8'h5f:   sept = 7'h11;
            8'hc6:   sept = 7'h1c;
            8'he6:   sept = 7'h1d;
            8'hdf:   sept = 7'h1e;
            8'hc9:   sept = 7'h1f;
            8'ha4:   sept = 7'h24;
            8'ha1:   sept = 7'h40;
            8'hc4:   sept = 7'h5b;
            8'hd6:   sept = 7'h5c;
            8'hd1:   sept = 7'h5d;
            8'hdc:   sept = 7'h5e;
            8'ha7:   sept = 7'h5f;
            8'hbf:   sept = 7'h60;
            8'he4:   sept = 7'h7b;
            8'hf6:   sept = 7'h7c;
            8'hf1:   sept = 7'h7d;
            8'hfc:   sept = 7'h7e;
            8'he0:   sept = 7'h7f;
            default: sept = UNKNOWN_SEPTET;
         endcase
      end
      return sept;
   endfunction

endpackage

>>> sv/gsp_front.sv
// Front end: accepts characters, translates them to septets, pushes to the queue.
// Depends on gsp_pkg.
module gsp_front
   import gsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_char_code,
   input  logic         req_last_char,
   input  q_status_type q_status,
   output logic         push,
   output q_entry_type  push_data
);

   logic        f_valid_ff, f_valid_in;
   q_entry_type f_entry_ff;
   logic        take;

   // stage register frees whenever the queue has room
   assign push      = f_valid_ff && !q_status.full;
   assign req_ready = !f_valid_ff || !q_status.full;
   assign take      = req_valid && req_ready;
   assign push_data = f_entry_ff;

   always_comb begin
      f_valid_in = f_valid_ff;
      if (take) begin
         f_valid_in = 1'b1;
      end else if (push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   // translate on the way in
   always_ff @(posedge clock) begin
      if (take) begin
         f_entry_ff.septet <= to_septet(req_char_code);
         f_entry_ff.last   <= req_last_char;
      end
   end

endmodule

>>> sv/gsp_queue.sv
// Short flop-based queue of translated septets between front and back ends.
// Depends on gsp_pkg.
module gsp_queue
   import gsp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_data,
   input  logic         pop,
   output q_entry_type  head_data,
   output q_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   q_entry_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign head_data    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/gsp_back.sv
// Back end: packs septets LSB first into octets and drives the result channel.
// Depends on gsp_pkg; fed by gsp_queue.
module gsp_back
   import gsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  q_entry_type     q_head,
   input  q_status_type    q_status,
   output logic            pop,
   input  logic [2:0]      fill_bits,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_octet,
   output logic            rsp_last_octet,
   output back_status_type status
);

   // packer state
   logic       start_ff, start_in;
   logic [2:0] bits_ff, bits_in;
   logic [6:0] partial_ff, partial_in;
   // output register and pending flush word
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_octet_ff, out_octet_in;
   logic       out_last_ff, out_last_in;
   logic       flush_ff, flush_in;
   logic [7:0] flush_octet_ff, flush_octet_in;

   logic [2:0]  held;
   logic [6:0]  part;
   logic [14:0] acc;
   logic        has_full;
   logic [2:0]  new_held;
   logic [6:0]  new_part;
   logic        need_out;
   logic        second_out;
   logic        first_last;
   logic        out_free;

   // shift-and-or of the head septet into the held bits
   always_comb begin
      held       = start_ff ? fill_bits : bits_ff;
      part       = start_ff ? 7'd0 : partial_ff;
      acc        = {8'd0, part} | ({8'd0, q_head.septet} << held);
      has_full   = (held != 3'd0);
      new_held   = has_full ? held - 3'd1 : 3'd7;
      new_part   = has_full ? acc[14:8] : acc[6:0];
      need_out   = has_full || q_head.last;
      second_out = has_full && q_head.last && (new_held != 3'd0);
      first_last = q_head.last && (!has_full || new_held == 3'd0);
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = q_status.valid && !flush_ff && (out_free || !need_out);

   // packer state update
   always_comb begin
      start_in   = start_ff;
      bits_in    = bits_ff;
      partial_in = partial_ff;
      if (pop) begin
         if (q_head.last) begin
            start_in   = 1'b1;
            bits_in    = 3'd0;
            partial_in = 7'd0;
         end else begin
            start_in   = 1'b0;
            bits_in    = new_held;
            partial_in = new_part;
         end
      end
   end

   // output word and flush word
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_octet_in   = out_octet_ff;
      out_last_in    = out_last_ff;
      flush_in       = flush_ff;
      flush_octet_in = flush_octet_ff;
      if (out_free) begin
         if (flush_ff) begin
            out_valid_in = 1'b1;
            out_octet_in = flush_octet_ff;
            out_last_in  = 1'b1;
            flush_in     = 1'b0;
         end else if (pop && need_out) begin
            out_valid_in = 1'b1;
            out_octet_in = acc[7:0];
            out_last_in  = first_last;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (pop && second_out) begin
         flush_in       = 1'b1;
         flush_octet_in = {1'b0, new_part};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         bits_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         start_ff     <= start_in;
         bits_ff      <= bits_in;
         out_valid_ff <= out_valid_in;
         flush_ff     <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff     <= partial_in;
      out_octet_ff   <= out_octet_in;
      out_last_ff    <= out_last_in;
      flush_octet_ff <= flush_octet_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_octet            = out_octet_ff;
   assign rsp_last_octet       = out_last_ff;
   assign status.flush_pending = flush_ff;
   assign status.at_start      = start_ff;

endmodule

>>> sv/gsm_septet_packer.sv
// Top level of the GSM default-alphabet septet packer.
// Depends on gsp_pkg, gsp_front, gsp_queue and gsp_back.
//
// Usage:
//   req channel: one Latin-1 character per word (req_char_code), with
//   req_last_char set on the final character of a message.
//   rsp channel: packed octets, septet bits LSB first; rsp_last_octet marks
//   the final octet of the message, which carries any partial flush.
//   APB port: register fill_bits at address 0 sets the zero fill bits ahead
//   of the first septet; it is sampled at the first character of a message.
// Path: a character passes through the front stage register, the queue and
//   the output register of the back end. Throughput is one character per
//   cycle while the receiver takes each octet; the flush word, when a last
//   character yields two octets, holds the queue back behind the output word.
// Reset clears the queue, the output word and the packer, so the next
//   character starts a new message. When the receiver stalls, the output
//   word holds, queue (QDEPTH words) and front stage fill; req_ready drops.
module gsm_septet_packer
   import gsp_pkg::*;
#(
   parameter int QDEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_octet,
   output logic        rsp_last_octet,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]      fill_ff, fill_in;
   logic            csr_write;
   logic            push;
   logic            pop;
   q_entry_type     push_data;
   q_entry_type     q_head;
   q_status_type    q_status;
   back_status_type b_status;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_FILL_BITS);
   assign fill_in   = csr_write ? pwdata[2:0] : fill_ff;
   assign prdata    = (paddr[2] == CSR_FILL_BITS) ? {29'd0, fill_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   gsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   gsp_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (q_head),
      .status    (q_status)
   );

   gsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_status       (q_status),
      .pop            (pop),
      .fill_bits      (fill_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_octet      (rsp_octet),
      .rsp_last_octet (rsp_last_octet),
      .status         (b_status)
   );

`ifndef ASSERT_OFF
   // a flush word only waits behind a word already on the output
   a_flush_behind_out: assert property (@(posedge clock) disable iff (reset)
      b_status.flush_pending |-> rsp_valid)
      else $error("flush word pending with no output word");

   // the front never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("push into full queue");

   // leaving reset finds nothing queued, nothing shown and a fresh message
   a_reset_clean: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !q_status.valid && b_status.at_start))
      else $error("state not cleared by reset");
`endif

endmodule
